// ===== rtl/core/ksd_pkg.sv =====
`default_nettype none
package ksd_pkg;

    // Keymap geometry: two columns per row
    localparam int KEYMAP_ROWS    = 128;
    localparam int KEY_WIDTH      = 16;
    localparam int KEYMAP_ENTRIES = KEYMAP_ROWS * 2;
    localparam int MAP_AW         = $clog2(KEYMAP_ENTRIES);
    localparam int ROW_W          = $clog2(KEYMAP_ROWS);
    localparam int MOD_W          = 6;

    // Operation codes
    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Scancode constants
    localparam logic [7:0] SC_E0       = 8'hE0;
    localparam logic [7:0] SC_E1       = 8'hE1;
    localparam logic [7:0] SC_PS_MAKE  = 8'h2A;
    localparam logic [7:0] SC_PS_BREAK = 8'hB7;
    localparam logic [7:0] SC_CTRL_MK  = 8'h1D;
    localparam logic [7:0] SC_CTRL_BK  = 8'h9D;
    localparam logic [7:0] SC_ALT_MK   = 8'h38;
    localparam logic [7:0] SC_ALT_BK   = 8'hB8;
    localparam logic [6:0] ROW_SHIFT_L = 7'h2A;
    localparam logic [6:0] ROW_SHIFT_R = 7'h36;
    localparam logic [6:0] ROW_CTRL_L  = 7'h1D;
    localparam logic [6:0] ROW_ALT_L   = 7'h38;
    localparam logic [2:0] PAUSE_LEN   = 3'd6;

    // Modifier bit positions
    localparam int MOD_SHIFT_L = 0;
    localparam int MOD_SHIFT_R = 1;
    localparam int MOD_CTRL_L  = 2;
    localparam int MOD_CTRL_R  = 3;
    localparam int MOD_ALT_L   = 4;
    localparam int MOD_ALT_R   = 5;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PAUSE,
        SEQ_E0,
        SEQ_PSM_E0,
        SEQ_PSM_37,
        SEQ_PSB_E0,
        SEQ_PSB_AA
    } seq_state_t;

    typedef struct packed {
        logic                 op;
        logic [7:0]           scan_byte;
        logic [ROW_W-1:0]     map_row;
        logic                 map_column;
        logic [KEY_WIDTH-1:0] map_value;
    } ksd_in_t;

    typedef struct packed {
        logic                 key_valid;
        logic [KEY_WIDTH-1:0] key_code;
        logic [MOD_W-1:0]     modifiers;
    } ksd_out_t;

    // Sequencer verdict for one byte
    typedef struct packed {
        logic              lookup;
        logic [MAP_AW-1:0] addr;
        logic [MOD_W-1:0]  modifiers;
    } ksd_look_t;

    // Expected byte at each place of the pause sequence
    function automatic logic [7:0] pause_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = 8'hE1;
            3'd1:    b = 8'h1D;
            3'd2:    b = 8'h45;
            3'd3:    b = 8'hE1;
            3'd4:    b = 8'h9D;
            3'd5:    b = 8'hC5;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ksd_ram.sv =====
`default_nettype none
module ksd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ksd_seq.sv =====
`default_nettype none
module ksd_seq
    import ksd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic [7:0] scan_byte,
    output ksd_look_t       look
);

    seq_state_t       state_reg, state_next;
    logic [2:0]       pos_reg, pos_next;
    logic [MOD_W-1:0] mods_reg, mods_next;

    logic [6:0] row;
    logic       make;
    logic       col;

    assign row  = scan_byte[6:0];
    assign make = ~scan_byte[7];
    assign col  = mods_reg[MOD_SHIFT_L] | mods_reg[MOD_SHIFT_R];

    // Hold sequence and modifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pos_reg   <= 3'd0;
            mods_reg  <= '0;
        end
        else if (en)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            mods_reg  <= mods_next;
        end
    end

    // Decode one byte
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        mods_next   = mods_reg;
        look.lookup = 1'b0;
        look.addr   = {row, col};
        unique case (state_reg)
            SEQ_PAUSE:
            begin
                if (pos_reg < PAUSE_LEN && scan_byte == pause_byte(pos_reg))
                begin
                    pos_next = pos_reg + 3'd1;
                    if (pos_next >= PAUSE_LEN)
                    begin
                        state_next = SEQ_IDLE;
                        pos_next   = 3'd0;
                    end
                end
                else
                begin
                    state_next = SEQ_IDLE;
                    pos_next   = 3'd0;
                end
            end
            SEQ_E0:
            begin
                state_next = SEQ_IDLE;
                unique case (scan_byte)
                    SC_PS_MAKE:  state_next = SEQ_PSM_E0;
                    SC_PS_BREAK: state_next = SEQ_PSB_E0;
                    SC_CTRL_MK:  mods_next[MOD_CTRL_R] = 1'b1;
                    SC_CTRL_BK:  mods_next[MOD_CTRL_R] = 1'b0;
                    SC_ALT_MK:   mods_next[MOD_ALT_R]  = 1'b1;
                    SC_ALT_BK:   mods_next[MOD_ALT_R]  = 1'b0;
                    default:     ;
                endcase
            end
            SEQ_PSM_E0:
            begin
                state_next = (scan_byte == SC_E0) ? SEQ_PSM_37 : SEQ_IDLE;
            end
            SEQ_PSB_E0:
            begin
                state_next = (scan_byte == SC_E0) ? SEQ_PSB_AA : SEQ_IDLE;
            end
            SEQ_PSM_37, SEQ_PSB_AA:
            begin
                state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
                pos_next   = 3'd0;
                if (scan_byte == SC_E1)
                begin
                    state_next = SEQ_PAUSE;
                    pos_next   = 3'd1;
                end
                else if (scan_byte == SC_E0)
                begin
                    state_next = SEQ_E0;
                end
                else
                begin
                    unique case (row)
                        ROW_SHIFT_L: mods_next[MOD_SHIFT_L] = make;
                        ROW_SHIFT_R: mods_next[MOD_SHIFT_R] = make;
                        ROW_CTRL_L:  mods_next[MOD_CTRL_L]  = make;
                        ROW_ALT_L:   mods_next[MOD_ALT_L]   = make;
                        default:     look.lookup = make;
                    endcase
                end
            end
        endcase
        look.modifiers = mods_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/keyboard_scancode_decoder.sv =====
`default_nettype none
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall   ksd_in_t  (scancode byte or keymap write)
// out      output     out_valid/out_stall ksd_out_t (key, modifiers)
//
// One transaction per cycle sustained while out_stall stays low; a result passes from
// its input transaction through the registered keymap RAM read into the output register.
// Sequence and modifier state update at acceptance; the keymap RAM write and
// read both take place in the accepting cycle, so a lookup always sees earlier writes.
// Reset clears the sequencer, modifiers and pipeline valids; keymap contents
// are undefined until written. A stalled output backs up into the read stage
// and then into in_stall; the RAM read data holds while the read stage waits.
module keyboard_scancode_decoder
    import ksd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire ksd_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_stall,
    output ksd_out_t     out_data
);

    ksd_look_t            look;
    logic                 in_acc;
    logic                 is_scan;
    logic [KEY_WIDTH-1:0] rdata;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_lookup_reg;
    logic [MOD_W-1:0] s1_mods_reg;
    logic             s1_adv;
    logic             out_valid_reg, out_valid_next;
    ksd_out_t         out_reg;
    logic [MOD_W-1:0] u_mods_hold;
    logic [MOD_W-1:0] mods_seen_reg;

    // Stage advance and input acceptance
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_acc   = in_valid && !in_stall;
    assign is_scan  = (in_data.op == OP_SCAN);

    ksd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (in_acc && is_scan),
        .scan_byte (in_data.scan_byte),
        .look      (look)
    );

    ksd_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (KEYMAP_ENTRIES)
    ) u_keymap (
        .clk   (clk),
        .we    (in_acc && !is_scan),
        .waddr ({in_data.map_row, in_data.map_column}),
        .wdata (in_data.map_value),
        .re    (in_acc && is_scan && look.lookup),
        .raddr (look.addr),
        .rdata (rdata)
    );

    // Valid flags
    always_comb
    begin
        s1_valid_next = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture read-stage payload; a keymap write reports the unchanged modifiers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_lookup_reg <= is_scan && look.lookup;
            s1_mods_reg   <= is_scan ? look.modifiers : u_mods_hold;
        end
    end

    // Advance into the output register
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg.key_valid <= s1_lookup_reg && (rdata != '0);
            out_reg.key_code  <= s1_lookup_reg ? rdata : '0;
            out_reg.modifiers <= s1_mods_reg;
        end
    end

    // Modifier state as it stands, for transactions that leave it untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_seen_reg <= '0;
        end
        else if (in_acc && is_scan)
        begin
            mods_seen_reg <= look.modifiers;
        end
    end

    assign u_mods_hold = mods_seen_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A transaction is never taken over a stuck read stage
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (!s1_valid_reg || s1_adv))
        else $error("input accepted over a stuck read stage");

    // A waiting read-stage result reaches an empty output register next cycle
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid)
        else $error("read-stage result not advanced");

    // A reported key never carries a zero code
    a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.key_valid) |-> (out_data.key_code != '0))
        else $error("key reported with zero code");

endmodule
`default_nettype wire
